// ----- rtl/btlv_pkg.sv -----
`default_nettype none
package btlv_pkg;

  localparam logic [7:0] OID_MAX_INDEX = 8'd31;

  localparam logic [2:0] KIND_HEADER  = 3'd0;
  localparam logic [2:0] KIND_INTEGER = 3'd1;
  localparam logic [2:0] KIND_STRING  = 3'd2;
  localparam logic [2:0] KIND_ARC     = 3'd3;
  localparam logic [2:0] KIND_SKIPPED = 3'd4;
  localparam logic [2:0] KIND_ERROR   = 3'd5;

  localparam logic [2:0] ERR_SHORT_HEADER = 3'd0;
  localparam logic [2:0] ERR_WIDE_LENGTH  = 3'd1;
  localparam logic [2:0] ERR_OVERFLOW     = 3'd2;
  localparam logic [2:0] ERR_STRING_LONG  = 3'd3;
  localparam logic [2:0] ERR_ARCS         = 3'd4;

  localparam logic [7:0] TAG_INTEGER     = 8'h02;
  localparam logic [7:0] TAG_APP_INTEGER = 8'h41;
  localparam logic [7:0] TAG_STRING      = 8'h04;
  localparam logic [7:0] TAG_OID         = 8'h06;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first;
    logic [31:0] bytes_left;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  tag;
    logic [31:0] value;
    logic [2:0]  code;
    logic        last;
  } out_item_t;

endpackage
`default_nettype wire

// ----- rtl/ber_tlv_element_decoder_unit.sv -----
`default_nettype none
// BER TLV decoder: one encoded byte enters per cycle and its results (zero to three) are
// written into an 8-entry result queue in the same cycle, so they can leave from the next
// cycle on. The input takes a byte in every cycle while the queue has room for three
// results; while out_stall is low the output delivers one result per cycle, so an item
// with several results drains more slowly than it arrives; the queue absorbs the burst.
module ber_tlv_element_decoder_unit (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire btlv_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire                      out_stall,
  output btlv_pkg::out_item_t      out_data
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_LENX = 3'd2;
  localparam logic [2:0] PH_INT  = 3'd3;
  localparam logic [2:0] PH_STR  = 3'd4;
  localparam logic [2:0] PH_SKIP = 3'd5;
  localparam logic [2:0] PH_OID  = 3'd6;

  logic [2:0]  phase, phase_next;
  logic [7:0]  tag_seen, tag_seen_next;
  logic [2:0]  length_bytes_left, length_bytes_left_next;
  logic [31:0] length_acc, length_acc_next;
  logic [31:0] content_left, content_left_next;
  logic [31:0] buffer_left, buffer_left_next;
  logic [31:0] value_acc, value_acc_next;
  logic [7:0]  arc_index, arc_index_next;
  logic        arc_open, arc_open_next;

  btlv_pkg::out_item_t fifo [8];
  logic [2:0] wr_ptr, rd_ptr;
  logic [3:0] count;

  btlv_pkg::out_item_t res [3];
  logic [1:0] res_n;
  logic       accept, pop;

  assign in_stall  = (count > 4'd5);
  assign accept    = in_valid && !in_stall;
  assign out_valid = (count != 4'd0);
  assign pop       = out_valid && !out_stall;
  assign out_data  = fifo[rd_ptr];

  always_comb begin
    logic        do_hdr;
    logic [31:0] hlen;
    logic [6:0]  cnt;
    logic        oid_end;
    logic [7:0]  b;
    b = in_data.data_byte;
    phase_next = phase;
    tag_seen_next = tag_seen;
    length_bytes_left_next = length_bytes_left;
    length_acc_next = length_acc;
    content_left_next = content_left;
    buffer_left_next = buffer_left;
    value_acc_next = value_acc;
    arc_index_next = arc_index;
    arc_open_next = arc_open;
    do_hdr = 1'b0;
    hlen = '0;
    cnt = b[6:0];
    oid_end = 1'b0;
    res_n = 2'd0;
    for (int i = 0; i < 3; i++) begin
      res[i] = '0;
    end

    if (accept) begin
      if (in_data.first) begin
        tag_seen_next = b;
        if (in_data.bytes_left < 32'd2) begin
          res[0] = '{btlv_pkg::KIND_ERROR, b, 32'd0, btlv_pkg::ERR_SHORT_HEADER, 1'b1};
          res_n = 2'd1;
          phase_next = PH_IDLE;
        end else begin
          buffer_left_next = in_data.bytes_left - 32'd1;
          phase_next = PH_LEN;
        end
      end else begin
        unique case (phase)
          PH_LEN: begin
            buffer_left_next = buffer_left - 32'd1;
            if (b[7]) begin
              if (cnt > 7'd4) begin
                res[0] = '{btlv_pkg::KIND_ERROR, tag_seen, 32'd0,
                           btlv_pkg::ERR_WIDE_LENGTH, 1'b1};
                res_n = 2'd1;
                phase_next = PH_IDLE;
              end else if ({25'd0, cnt} > buffer_left_next) begin
                res[0] = '{btlv_pkg::KIND_ERROR, tag_seen, 32'd0,
                           btlv_pkg::ERR_OVERFLOW, 1'b1};
                res_n = 2'd1;
                phase_next = PH_IDLE;
              end else if (cnt == 7'd0) begin
                do_hdr = 1'b1;
              end else begin
                length_bytes_left_next = cnt[2:0];
                length_acc_next = '0;
                phase_next = PH_LENX;
              end
            end else begin
              do_hdr = 1'b1;
              hlen = {24'd0, b};
            end
          end
          PH_LENX: begin
            buffer_left_next = buffer_left - 32'd1;
            length_acc_next = {length_acc[23:0], b};
            length_bytes_left_next = length_bytes_left - 3'd1;
            if (length_bytes_left_next == 3'd0) begin
              do_hdr = 1'b1;
              hlen = length_acc_next;
            end
          end
          PH_INT: begin
            value_acc_next = {value_acc[23:0], b};
            content_left_next = content_left - 32'd1;
            if (content_left_next == 32'd0) begin
              res[0] = '{btlv_pkg::KIND_INTEGER, tag_seen, value_acc_next, 3'd0, 1'b1};
              res_n = 2'd1;
              phase_next = PH_IDLE;
            end
          end
          PH_STR: begin
            content_left_next = content_left - 32'd1;
            res[0] = '{btlv_pkg::KIND_STRING, tag_seen, {24'd0, b}, 3'd0,
                       content_left_next == 32'd0};
            res_n = 2'd1;
            if (content_left_next == 32'd0) begin
              phase_next = PH_IDLE;
            end
          end
          PH_SKIP: begin
            content_left_next = content_left - 32'd1;
            if (content_left_next == 32'd0) begin
              res[0] = '{btlv_pkg::KIND_SKIPPED, tag_seen, 32'd0, 3'd0, 1'b1};
              res_n = 2'd1;
              phase_next = PH_IDLE;
            end
          end
          PH_OID: begin
            if (arc_index >= 8'd2 && !arc_open && arc_index > btlv_pkg::OID_MAX_INDEX) begin
              res[0] = '{btlv_pkg::KIND_ERROR, tag_seen, 32'd0, btlv_pkg::ERR_ARCS, 1'b1};
              res_n = 2'd1;
              phase_next = PH_IDLE;
            end else begin
              if (arc_index >= 8'd2) begin
                arc_open_next = 1'b1;
              end
              content_left_next = content_left - 32'd1;
              oid_end = (content_left_next == 32'd0);
              value_acc_next = {value_acc[24:0], b[6:0]};
              if (!b[7] || oid_end) begin
                if (arc_index == 8'd0) begin
                  // The first encoded arc carries the first two arcs, split by 40.
                  if (value_acc_next < 32'd40) begin
                    res[0] = '{btlv_pkg::KIND_ARC, tag_seen, 32'd0, 3'd0, 1'b0};
                    res[1] = '{btlv_pkg::KIND_ARC, tag_seen, value_acc_next, 3'd0, oid_end};
                  end else if (value_acc_next < 32'd80) begin
                    res[0] = '{btlv_pkg::KIND_ARC, tag_seen, 32'd1, 3'd0, 1'b0};
                    res[1] = '{btlv_pkg::KIND_ARC, tag_seen, value_acc_next - 32'd40,
                               3'd0, oid_end};
                  end else begin
                    res[0] = '{btlv_pkg::KIND_ARC, tag_seen, 32'd2, 3'd0, 1'b0};
                    res[1] = '{btlv_pkg::KIND_ARC, tag_seen, value_acc_next - 32'd80,
                               3'd0, oid_end};
                  end
                  res_n = 2'd2;
                  arc_index_next = 8'd2;
                end else begin
                  res[0] = '{btlv_pkg::KIND_ARC, tag_seen, value_acc_next, 3'd0, oid_end};
                  res_n = 2'd1;
                  arc_index_next = arc_index + 8'd1;
                end
                value_acc_next = '0;
                arc_open_next = 1'b0;
              end
              if (oid_end) begin
                phase_next = PH_IDLE;
              end
            end
          end
          default: begin
          end
        endcase

        if (do_hdr) begin
          if (hlen > buffer_left_next) begin
            res[0] = '{btlv_pkg::KIND_ERROR, tag_seen, 32'd0, btlv_pkg::ERR_OVERFLOW, 1'b1};
            res_n = 2'd1;
            phase_next = PH_IDLE;
          end else begin
            content_left_next = hlen;
            value_acc_next = '0;
            phase_next = PH_IDLE;
            res[0] = '{btlv_pkg::KIND_HEADER, tag_seen, hlen, 3'd0, 1'b0};
            res_n = 2'd1;
            if (tag_seen == btlv_pkg::TAG_INTEGER ||
                tag_seen == btlv_pkg::TAG_APP_INTEGER) begin
              if (hlen == 32'd0) begin
                res[1] = '{btlv_pkg::KIND_INTEGER, tag_seen, 32'd0, 3'd0, 1'b1};
                res_n = 2'd2;
              end else begin
                phase_next = PH_INT;
              end
            end else if (tag_seen == btlv_pkg::TAG_STRING) begin
              if (hlen > 32'd255) begin
                res[0] = '{btlv_pkg::KIND_ERROR, tag_seen, 32'd0,
                           btlv_pkg::ERR_STRING_LONG, 1'b1};
              end else if (hlen == 32'd0) begin
                res[0].last = 1'b1;
              end else begin
                phase_next = PH_STR;
              end
            end else if (tag_seen == btlv_pkg::TAG_OID) begin
              arc_index_next = '0;
              arc_open_next = 1'b0;
              if (hlen == 32'd0) begin
                res[1] = '{btlv_pkg::KIND_ARC, tag_seen, 32'd0, 3'd0, 1'b0};
                res[2] = '{btlv_pkg::KIND_ARC, tag_seen, 32'd0, 3'd0, 1'b1};
                res_n = 2'd3;
              end else begin
                phase_next = PH_OID;
              end
            end else begin
              if (hlen == 32'd0) begin
                res[1] = '{btlv_pkg::KIND_SKIPPED, tag_seen, 32'd0, 3'd0, 1'b1};
                res_n = 2'd2;
              end else begin
                phase_next = PH_SKIP;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      tag_seen <= '0;
      length_bytes_left <= '0;
      length_acc <= '0;
      content_left <= '0;
      buffer_left <= '0;
      value_acc <= '0;
      arc_index <= '0;
      arc_open <= 1'b0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      phase <= phase_next;
      tag_seen <= tag_seen_next;
      length_bytes_left <= length_bytes_left_next;
      length_acc <= length_acc_next;
      content_left <= content_left_next;
      buffer_left <= buffer_left_next;
      value_acc <= value_acc_next;
      arc_index <= arc_index_next;
      arc_open <= arc_open_next;
      wr_ptr <= wr_ptr + {1'b0, res_n};
      rd_ptr <= rd_ptr + {2'b0, pop};
      count <= count + {2'b0, res_n} - {3'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < res_n) begin
        fifo[wr_ptr + 3'(i)] <= res[i];
      end
    end
  end

endmodule
`default_nettype wire

// ----- sim/ber_tlv_element_decoder_unit_tb.sv -----
`timescale 1ns / 100ps

module ber_tlv_element_decoder_unit_tb;

  localparam logic [7:0] TAG_NULL = 8'h05;
  localparam logic [7:0] LEN_LONG = 8'h80;
  localparam logic [2:0] NO_CODE = 3'd0;
  localparam int CYCLE_LIMIT = 200000;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LEN, ST_LENX, ST_INT, ST_STR, ST_SKIP, ST_OID
  } parse_state_t;

  class decoded_result_checker;
    btlv_pkg::out_item_t awaited[$];
    int errors;
    int checked;
    int kind_hits[6];
    parse_state_t state;
    logic [7:0] cur_tag;
    logic [2:0] len_bytes;
    logic [31:0] len_acc;
    logic [31:0] content_left;
    logic [31:0] buf_left;
    logic [31:0] acc;
    logic [7:0] arc_idx;
    logic arc_open;

    function new();
      state = ST_IDLE;
      cur_tag = '0;
      len_bytes = '0;
      len_acc = '0;
      content_left = '0;
      buf_left = '0;
      acc = '0;
      arc_idx = '0;
      arc_open = 1'b0;
      errors = 0;
      checked = 0;
      foreach (kind_hits[i]) kind_hits[i] = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void push(logic [2:0] kind, logic [31:0] value, logic last);
      btlv_pkg::out_item_t r;
      r.kind = kind;
      r.tag = cur_tag;
      r.value = value;
      r.code = NO_CODE;
      r.last = last;
      awaited.push_back(r);
    endfunction

    function void raise(logic [2:0] code);
      btlv_pkg::out_item_t r;
      r.kind = btlv_pkg::KIND_ERROR;
      r.tag = cur_tag;
      r.value = '0;
      r.code = code;
      r.last = 1'b1;
      awaited.push_back(r);
      state = ST_IDLE;
    endfunction

    function void finish_header(logic [31:0] len);
      if (len > buf_left) begin
        raise(btlv_pkg::ERR_OVERFLOW);
        return;
      end
      content_left = len;
      acc = '0;
      state = ST_IDLE;
      if (cur_tag == btlv_pkg::TAG_INTEGER || cur_tag == btlv_pkg::TAG_APP_INTEGER) begin
        push(btlv_pkg::KIND_HEADER, len, 1'b0);
        if (len == 0) push(btlv_pkg::KIND_INTEGER, '0, 1'b1);
        else state = ST_INT;
      end else if (cur_tag == btlv_pkg::TAG_STRING) begin
        if (len > 32'd255) begin
          raise(btlv_pkg::ERR_STRING_LONG);
          return;
        end
        push(btlv_pkg::KIND_HEADER, len, len == 0);
        if (len != 0) state = ST_STR;
      end else if (cur_tag == btlv_pkg::TAG_OID) begin
        push(btlv_pkg::KIND_HEADER, len, 1'b0);
        arc_idx = '0;
        arc_open = 1'b0;
        if (len == 0) begin
          push(btlv_pkg::KIND_ARC, '0, 1'b0);
          push(btlv_pkg::KIND_ARC, '0, 1'b1);
        end else begin
          state = ST_OID;
        end
      end else begin
        push(btlv_pkg::KIND_HEADER, len, 1'b0);
        if (len == 0) push(btlv_pkg::KIND_SKIPPED, '0, 1'b1);
        else state = ST_SKIP;
      end
    endfunction

    function void take_oid_byte(logic [7:0] b);
      logic done;
      if (arc_idx >= 8'd2 && !arc_open) begin
        if (arc_idx > btlv_pkg::OID_MAX_INDEX) begin
          raise(btlv_pkg::ERR_ARCS);
          return;
        end
        arc_open = 1'b1;
      end
      content_left--;
      done = (content_left == 0);
      acc = {acc[24:0], b[6:0]};
      if (!b[7] || done) begin
        if (arc_idx == 0) begin
          // The first subidentifier carries two arcs.
          if (acc < 32'd80) begin
            push(btlv_pkg::KIND_ARC, acc / 32'd40, 1'b0);
            push(btlv_pkg::KIND_ARC, acc % 32'd40, done);
          end else begin
            push(btlv_pkg::KIND_ARC, 32'd2, 1'b0);
            push(btlv_pkg::KIND_ARC, acc - 32'd80, done);
          end
          arc_idx = 8'd2;
        end else begin
          push(btlv_pkg::KIND_ARC, acc, done);
          arc_idx++;
        end
        acc = '0;
        arc_open = 1'b0;
      end
      if (done) state = ST_IDLE;
    endfunction

    function void note_byte(btlv_pkg::in_item_t it);
      logic [7:0] b;
      logic [31:0] cnt;
      b = it.data_byte;
      if (it.first) begin
        cur_tag = b;
        if (it.bytes_left < 32'd2) begin
          raise(btlv_pkg::ERR_SHORT_HEADER);
          return;
        end
        buf_left = it.bytes_left - 32'd1;
        state = ST_LEN;
        return;
      end
      case (state)
        ST_LEN: begin
          buf_left--;
          if (b[7]) begin
            cnt = {25'd0, b[6:0]};
            if (cnt > 32'd4) raise(btlv_pkg::ERR_WIDE_LENGTH);
            else if (cnt > buf_left) raise(btlv_pkg::ERR_OVERFLOW);
            else if (cnt == 0) finish_header('0);
            else begin
              len_bytes = cnt[2:0];
              len_acc = '0;
              state = ST_LENX;
            end
          end else begin
            finish_header({24'd0, b});
          end
        end
        ST_LENX: begin
          buf_left--;
          len_acc = {len_acc[23:0], b};
          len_bytes--;
          if (len_bytes == 0) finish_header(len_acc);
        end
        ST_INT: begin
          acc = {acc[23:0], b};
          content_left--;
          if (content_left == 0) begin
            push(btlv_pkg::KIND_INTEGER, acc, 1'b1);
            state = ST_IDLE;
          end
        end
        ST_STR: begin
          content_left--;
          push(btlv_pkg::KIND_STRING, {24'd0, b}, content_left == 0);
          if (content_left == 0) state = ST_IDLE;
        end
        ST_SKIP: begin
          content_left--;
          if (content_left == 0) begin
            push(btlv_pkg::KIND_SKIPPED, '0, 1'b1);
            state = ST_IDLE;
          end
        end
        ST_OID: take_oid_byte(b);
        default: ;
      endcase
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task check_result(btlv_pkg::out_item_t got);
      btlv_pkg::out_item_t want;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected result kind %0d tag %h value %h code %0d last %0d",
                         got.kind, got.tag, got.value, got.code, got.last));
        return;
      end
      want = awaited.pop_front();
      if (got.kind !== want.kind || got.tag !== want.tag || got.value !== want.value ||
          got.code !== want.code || got.last !== want.last) begin
        report($sformatf("result %0d: got %0d/%h/%h/%0d/%0d, want %0d/%h/%h/%0d/%0d",
                         checked, got.kind, got.tag, got.value, got.code, got.last,
                         want.kind, want.tag, want.value, want.code, want.last));
      end else begin
        kind_hits[want.kind]++;
      end
      checked++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  btlv_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall;
  btlv_pkg::out_item_t out_data;

  decoded_result_checker chk;
  logic [7:0] elem_q[$];
  logic [7:0] body_q[$];
  int burst_left;
  int rush_left;
  int elem_bytes;
  int stray_bytes;
  int hold_requests;
  int hold_served;
  int hold_cnt;
  int pat_cycle;
  int stall_mode;
  int cycle_count;

  ber_tlv_element_decoder_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) chk.check_result(out_data);
  end

  // Receiver: random stall modes, plus one long hold-off on request from the stimulus.
  initial begin
    out_stall = 1'b0;
    hold_served = 0;
    hold_cnt = 0;
    pat_cycle = 0;
    stall_mode = 0;
    forever begin
      @(negedge clk);
      pat_cycle++;
      if (pat_cycle % 40 == 0) stall_mode = $urandom_range(0, 3);
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else if (hold_requests != hold_served) begin
        hold_served = hold_requests;
        hold_cnt = 199;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 9) < 6);
          default: out_stall <= (pat_cycle % 3 == 0);
        endcase
      end
    end
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  task automatic put_byte(input logic [7:0] b, input logic is_first, input logic [31:0] left);
    btlv_pkg::in_item_t item;
    int gap;
    item.data_byte = b;
    item.first = is_first;
    item.bytes_left = left;
    if (burst_left == 0 && rush_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    chk.note_byte(item);
    if (burst_left > 0) burst_left--;
    if (rush_left > 0) rush_left--;
  endtask

  task automatic feed_elem(input logic [31:0] left);
    put_byte(elem_q[0], 1'b1, left);
    for (int i = 1; i < elem_q.size(); i++) put_byte(elem_q[i], 1'b0, $urandom);
    elem_bytes += elem_q.size();
  endtask

  task automatic stray(input logic [7:0] b);
    put_byte(b, 1'b0, $urandom);
    stray_bytes++;
  endtask

  task automatic pause_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk);
  endtask

  function automatic void add_len(int unsigned len);
    int nb;
    logic [31:0] v;
    v = len;
    if (len < 128 && $urandom_range(0, 3) != 0) begin
      elem_q.push_back(8'(len));
    end else begin
      nb = 0;
      while (nb < 4 && (v >> (8 * nb)) != 0) nb++;
      nb = nb + $urandom_range(0, 4 - nb);
      elem_q.push_back(LEN_LONG | 8'(nb));
      for (int i = nb - 1; i >= 0; i--) elem_q.push_back(8'(v >> (8 * i)));
    end
  endfunction

  function automatic void add_base128(logic [31:0] v);
    int g;
    g = 1;
    while (g < 5 && (v >> (7 * g)) != 0) g++;
    for (int i = g - 1; i >= 0; i--) body_q.push_back({i != 0, 7'(v >> (7 * i))});
  endfunction

  task automatic random_element(input bit many_arcs);
    int unsigned pick;
    int unsigned size;
    int len;
    bit assembled;
    logic [7:0] t;
    logic [31:0] left;
    body_q.delete();
    elem_q.delete();
    pick = many_arcs ? 40 : $urandom_range(0, 99);
    len = -1;
    assembled = 1'b1;
    if (pick < 22) begin
      t = $urandom_range(0, 1) ? btlv_pkg::TAG_INTEGER : btlv_pkg::TAG_APP_INTEGER;
      repeat ($urandom_range(0, 6)) body_q.push_back(rand_byte());
    end else if (pick < 40) begin
      t = btlv_pkg::TAG_STRING;
      if ($urandom_range(0, 15) == 0) len = $urandom_range(256, 70000);
      else repeat ($urandom_range(0, 10)) body_q.push_back(rand_byte());
    end else if (pick < 64) begin
      t = btlv_pkg::TAG_OID;
      if (many_arcs || $urandom_range(0, 7) != 0) begin
        add_base128($urandom_range(0, 1) ? $urandom_range(0, 119) : $urandom_range(0, 20000));
        repeat (many_arcs ? 32 : $urandom_range(0, 5)) begin
          add_base128(many_arcs ? $urandom_range(0, 127) : $urandom >> $urandom_range(0, 31));
        end
        // A very long arc wraps the accumulator.
        if ($urandom_range(0, 7) == 0) begin
          repeat (6) body_q.push_back(LEN_LONG | rand_byte());
          body_q.push_back(rand_byte() & 8'h7F);
        end
        // Content may end in the middle of an arc.
        if ($urandom_range(0, 5) == 0) body_q.push_back(LEN_LONG | rand_byte());
      end
    end else if (pick < 80) begin
      if ($urandom_range(0, 3) == 0) begin
        t = TAG_NULL;
      end else begin
        do t = rand_byte();
        while (t == btlv_pkg::TAG_INTEGER || t == btlv_pkg::TAG_APP_INTEGER ||
               t == btlv_pkg::TAG_STRING || t == btlv_pkg::TAG_OID);
      end
      repeat ($urandom_range(0, 8)) body_q.push_back(rand_byte());
    end else if (pick < 92) begin
      assembled = 1'b0;
      t = rand_byte();
      elem_q.push_back(t);
      case ($urandom_range(0, 2))
        0: elem_q.push_back(8'($urandom_range(133, 255)));
        1: elem_q.push_back(LEN_LONG);
        default: ;
      endcase
    end else begin
      repeat ($urandom_range(1, 3)) stray(rand_byte());
      return;
    end
    if (assembled) begin
      elem_q.push_back(t);
      add_len(len >= 0 ? len : body_q.size());
      foreach (body_q[i]) elem_q.push_back(body_q[i]);
    end
    size = elem_q.size();
    pick = $urandom_range(0, 99);
    if (pick < 10) left = $urandom_range(0, size - 1);
    else if (pick < 15) left = $urandom;
    else left = size + $urandom_range(0, 40);
    // Now and then a new element cuts this one short.
    if (size > 1 && $urandom_range(0, 11) == 0) begin
      size = $urandom_range(1, size - 1);
      while (elem_q.size() > size) elem_q.pop_back();
    end
    feed_elem(left);
  endtask

  initial begin
    int rand_start;
    bit held;
    bit paused;
    chk = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    burst_left = 0;
    rush_left = 0;
    elem_bytes = 0;
    stray_bytes = 0;
    hold_requests = 0;
    held = 1'b0;
    paused = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    stray(8'h55);
    elem_q = '{btlv_pkg::TAG_INTEGER, 8'h01, 8'h7F};
    feed_elem(32'd3);
    elem_q = '{btlv_pkg::TAG_APP_INTEGER, 8'h04, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    feed_elem(32'hFFFF_FFFF);
    elem_q = '{btlv_pkg::TAG_INTEGER, 8'h00};
    feed_elem(32'd2);
    elem_q = '{btlv_pkg::TAG_INTEGER, 8'h05, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05};
    feed_elem(32'd7);
    elem_q = '{btlv_pkg::TAG_STRING, 8'h03, 8'h00, 8'h80, 8'hFF};
    feed_elem(32'd10);
    elem_q = '{btlv_pkg::TAG_STRING, 8'h00};
    feed_elem(32'd2);
    elem_q = '{btlv_pkg::TAG_STRING, LEN_LONG | 8'd2, 8'h01, 8'h00};
    feed_elem(32'd300);
    stray(8'hAA);
    elem_q = '{btlv_pkg::TAG_STRING, LEN_LONG | 8'd1, 8'h02, 8'h41, 8'h42};
    feed_elem(32'd5);
    elem_q = '{TAG_NULL, 8'h00};
    feed_elem(32'd2);
    elem_q = '{8'h30, 8'h02, 8'h01, 8'h00};
    feed_elem(32'd4);
    elem_q = '{8'hFF, LEN_LONG | 8'd4, 8'h00, 8'h00, 8'h00, 8'h01, 8'h7E};
    feed_elem(32'd7);
    elem_q = '{btlv_pkg::TAG_OID, 8'h03, 8'h2B, 8'h06, 8'h01};
    feed_elem(32'd5);
    elem_q = '{btlv_pkg::TAG_OID, 8'h00};
    feed_elem(32'd2);
    elem_q = '{btlv_pkg::TAG_OID, 8'h02, 8'h88, 8'h37};
    feed_elem(32'd4);
    elem_q = '{btlv_pkg::TAG_OID, 8'h02, 8'h2B, 8'h81};
    feed_elem(32'd4);
    elem_q = '{btlv_pkg::TAG_OID, 8'h01, 8'hFF};
    feed_elem(32'h8000_0000);
    elem_q = '{btlv_pkg::TAG_INTEGER};
    feed_elem(32'd1);
    elem_q = '{8'h00};
    feed_elem(32'd0);
    elem_q = '{btlv_pkg::TAG_INTEGER, LEN_LONG | 8'd5};
    feed_elem(32'd10);
    elem_q = '{btlv_pkg::TAG_INTEGER, 8'hFF};
    feed_elem(32'd10);
    elem_q = '{btlv_pkg::TAG_INTEGER, LEN_LONG | 8'd4, 8'h00};
    feed_elem(32'd3);
    elem_q = '{btlv_pkg::TAG_STRING, 8'h05, 8'h61};
    feed_elem(32'd4);
    elem_q = '{btlv_pkg::TAG_INTEGER, LEN_LONG};
    feed_elem(32'd2);
    elem_q = '{btlv_pkg::TAG_INTEGER, 8'h04, 8'h11, 8'h22};
    feed_elem(32'd6);
    elem_q = '{btlv_pkg::TAG_STRING, 8'h01, 8'h5A};
    feed_elem(32'd3);
    pause_until_drained();

    rand_start = elem_bytes;
    random_element(1'b1);
    while (elem_bytes - rand_start < 56) begin
      if (!held) begin
        // Long output hold-off while input keeps coming, so the result queue fills.
        held = 1'b1;
        hold_requests++;
        rush_left = 16;
      end
      if (!paused && held && rush_left == 0) begin
        paused = 1'b1;
        pause_until_drained();
      end
      random_element(1'b0);
    end

    pause_until_drained();
    repeat (20) @(posedge clk);
    if (chk.pending() != 0) chk.report($sformatf("%0d results never arrived", chk.pending()));

    $display("Fed %0d element bytes and %0d stray bytes; checked %0d results.",
             elem_bytes, stray_bytes, chk.checked);
    $display("Matched %0d headers, %0d integers, %0d string bytes, %0d arcs, %0d skips, %s",
             chk.kind_hits[btlv_pkg::KIND_HEADER], chk.kind_hits[btlv_pkg::KIND_INTEGER],
             chk.kind_hits[btlv_pkg::KIND_STRING], chk.kind_hits[btlv_pkg::KIND_ARC],
             chk.kind_hits[btlv_pkg::KIND_SKIPPED],
             $sformatf("%0d errors.", chk.kind_hits[btlv_pkg::KIND_ERROR]));
    if (chk.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
